@@ rtl/sngx_pkg.sv @@
package sngx_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned GainW   = 17;
  localparam int unsigned ThreshW = 23;
  localparam int unsigned CoeffW  = 16;
  localparam int unsigned SlopeW  = 26;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 26;

  // shared multiplier operands and accumulator
  localparam int unsigned MulAW = 26;
  localparam int unsigned MulBW = 24;
  localparam int unsigned AccW  = MulAW + MulBW;

  localparam logic [GainW-1:0]   Unity     = 17'h10000;
  localparam logic [SampleW-1:0] PosMax    = 24'h7fffff;
  localparam logic [SampleW-1:0] NegMagMax = 24'h800000;
  localparam logic [AccW-1:0]    RndQ16    = AccW'(32768);
  localparam logic [AccW-1:0]    RndQ23    = AccW'(4194304);

  localparam logic [GainW-1:0]   RstInputGain = 17'd19661;
  localparam logic               RstGateEn    = 1'b0;
  localparam logic [ThreshW-1:0] RstThreshold = 23'd83886;
  localparam logic [CoeffW-1:0]  RstAttack    = 16'd64177;
  localparam logic [CoeffW-1:0]  RstRelease   = 16'd65508;
  localparam logic [SlopeW-1:0]  RstSlope     = 26'd5898240;
  localparam logic               RstBypass    = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INPUT_GAIN      = 3'd0,
    REG_GATE_ENABLE     = 3'd1,
    REG_GATE_THRESHOLD  = 3'd2,
    REG_ATTACK_COEFF    = 3'd3,
    REG_RELEASE_COEFF   = 3'd4,
    REG_EXPANSION_SLOPE = 3'd5,
    REG_BYPASS          = 3'd6
  } cfg_reg_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SCALE = 10'b0000000010,
    ST_LEVEL = 10'b0000000100,
    ST_ENV_A = 10'b0000001000,
    ST_ENV_B = 10'b0000010000,
    ST_DROP  = 10'b0000100000,
    ST_GAIN  = 10'b0001000000,
    ST_MULT  = 10'b0010000000,
    ST_STORE = 10'b0100000000,
    ST_SEND  = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic rnd_en;
  } mac_ctrl_t;

endpackage

@@ rtl/sngx_mac.sv @@
module sngx_mac (
  input  logic [sngx_pkg::MulAW-1:0] a_i,
  input  logic [sngx_pkg::MulBW-1:0] b_i,
  input  logic [sngx_pkg::AccW-1:0]  acc_i,
  input  sngx_pkg::mac_ctrl_t        ctrl_i,
  output logic [sngx_pkg::AccW-1:0]  res_o
);

  logic [sngx_pkg::AccW-1:0] prod;
  logic [sngx_pkg::AccW-1:0] addend;
  logic [sngx_pkg::AccW-1:0] rnd;

  assign prod   = sngx_pkg::AccW'(a_i) * sngx_pkg::AccW'(b_i);
  assign addend = ctrl_i.acc_en ? acc_i : '0;
  // half lsb of a q16 result
  assign rnd    = ctrl_i.rnd_en ? sngx_pkg::RndQ16 : '0;
  assign res_o  = prod + addend + rnd;

endmodule

@@ rtl/stereo_noise_gate_expander_unit.sv @@
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tdata: left_in, right_in; tlast: block_end_in
// m_axis    out        m_axis_tvalid/tready       tdata: left_out, right_out; tlast: block_end_out
// cfg       in         cfg_valid/cfg_ready        cfg_index (0..6), cfg_data
//
// a pair runs through the states of the left channel and then of the right, from the input transfer
// to the result entering the output register; the one 26x24 multiplier, used up to five times
// per channel in turn, sets that pace, and a disabled gate skips the envelope and gain steps.
// s_axis_tready is high only between pairs, so a new pair is taken only once the last is through.
// reset loads the register defaults and zeroes both envelopes at once, no clearing pass.
// a held output register stalls the sequencer at its last step until m_axis_tready is seen.
module stereo_noise_gate_expander_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sngx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sngx_pkg::CfgW-1:0]    cfg_data
);

  localparam int unsigned SW = sngx_pkg::SampleW;
  localparam int unsigned AW = sngx_pkg::AccW;

  sngx_pkg::state_e state_q, state_d;

  logic [sngx_pkg::GainW-1:0]   in_gain_q;
  logic                         gate_en_q;
  logic [sngx_pkg::ThreshW-1:0] thresh_q;
  logic [sngx_pkg::CoeffW-1:0]  attack_q;
  logic [sngx_pkg::CoeffW-1:0]  release_q;
  logic [sngx_pkg::SlopeW-1:0]  slope_q;
  logic                         bypass_q;

  logic [SW-1:0] env_q [2];
  logic [SW-1:0] env_d [2];

  logic          ch_q, ch_d;
  logic [SW-1:0] x_q [2];
  logic [SW-1:0] x_d [2];
  logic          last_q, last_d;
  logic [SW-1:0] lvl_q, lvl_d;
  logic          neg_q, neg_d;
  logic          below_q, below_d;
  logic [sngx_pkg::GainW-1:0] gain_q, gain_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [SW-1:0] yl_q, yl_d;

  logic          m_valid_q, m_valid_d;
  logic [47:0]   m_data_q, m_data_d;
  logic          m_last_q, m_last_d;

  logic [sngx_pkg::MulAW-1:0] mul_a;
  logic [sngx_pkg::MulBW-1:0] mul_b;
  sngx_pkg::mac_ctrl_t        mac_ctrl;
  logic [AW-1:0]              mac_res;

  logic [SW-1:0]   x_cur, x_mag, env_cur, env_new, y_val;
  logic [sngx_pkg::CoeffW-1:0] coef;
  logic [sngx_pkg::GainW-1:0]  coef_inv;
  logic [40:0]     rnd_scale;
  logic [24:0]     r_scale;
  logic [39:0]     rnd_out;
  logic [SW-1:0]   r_out;
  logic [AW-1:0]   rnd_drop;
  logic [26:0]     drop;
  logic [sngx_pkg::ThreshW-1:0] diff;
  logic            out_free;

  assign s_axis_tready = (state_q == sngx_pkg::ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  assign x_cur    = x_q[ch_q];
  assign x_mag    = x_cur[SW-1] ? (~x_cur + 1'b1) : x_cur;
  assign env_cur  = env_q[ch_q];
  assign coef     = (lvl_q > env_cur) ? attack_q : release_q;
  assign coef_inv = sngx_pkg::Unity - {1'b0, coef};

  assign rnd_scale = acc_q[40:0] + 41'd32768;
  assign r_scale   = rnd_scale[40:16];
  assign env_new   = acc_q[39:16];
  assign diff      = sngx_pkg::ThreshW'({1'b0, thresh_q} - env_new);
  assign rnd_drop  = acc_q + sngx_pkg::RndQ23;
  assign drop      = rnd_drop[49:23];
  assign rnd_out   = acc_q[39:0] + 40'd32768;
  assign r_out     = rnd_out[39:16];
  assign y_val     = neg_q ? (~r_out + 1'b1) : r_out;
  assign out_free  = !m_valid_q || m_axis_tready;

  sngx_mac u_mac (
    .a_i    (mul_a),
    .b_i    (mul_b),
    .acc_i  (acc_q),
    .ctrl_i (mac_ctrl),
    .res_o  (mac_res)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mac_ctrl = '0;
    unique case (state_q)
      sngx_pkg::ST_SCALE: begin
        mul_a = sngx_pkg::MulAW'(in_gain_q);
        mul_b = x_mag;
      end
      sngx_pkg::ST_ENV_A: begin
        mul_a = sngx_pkg::MulAW'(coef);
        mul_b = env_cur;
      end
      sngx_pkg::ST_ENV_B: begin
        mul_a           = sngx_pkg::MulAW'(coef_inv);
        mul_b           = lvl_q;
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.rnd_en = 1'b1;
      end
      sngx_pkg::ST_DROP: begin
        mul_a = slope_q;
        mul_b = sngx_pkg::MulBW'(diff);
      end
      sngx_pkg::ST_MULT: begin
        mul_a = sngx_pkg::MulAW'(gain_q);
        mul_b = lvl_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    x_d       = x_q;
    last_d    = last_q;
    lvl_d     = lvl_q;
    neg_d     = neg_q;
    below_d   = below_q;
    gain_d    = gain_q;
    acc_d     = acc_q;
    yl_d      = yl_q;
    env_d     = env_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    unique case (state_q)
      sngx_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_d[0]  = s_axis_tdata[23:0];
          x_d[1]  = s_axis_tdata[47:24];
          last_d  = s_axis_tlast;
          ch_d    = 1'b0;
          state_d = sngx_pkg::ST_SCALE;
        end
      end
      sngx_pkg::ST_SCALE: begin
        acc_d   = mac_res;
        state_d = sngx_pkg::ST_LEVEL;
      end
      sngx_pkg::ST_LEVEL: begin
        // round, then saturate the magnitude to the signed 24-bit range
        neg_d = x_cur[SW-1];
        if (x_cur[SW-1]) begin
          lvl_d = (r_scale > 25'(sngx_pkg::NegMagMax)) ? sngx_pkg::NegMagMax : r_scale[23:0];
        end else begin
          lvl_d = (r_scale > 25'(sngx_pkg::PosMax)) ? sngx_pkg::PosMax : r_scale[23:0];
        end
        if (gate_en_q) begin
          state_d = sngx_pkg::ST_ENV_A;
        end else begin
          gain_d  = sngx_pkg::Unity;
          state_d = sngx_pkg::ST_MULT;
        end
      end
      sngx_pkg::ST_ENV_A: begin
        acc_d   = mac_res;
        state_d = sngx_pkg::ST_ENV_B;
      end
      sngx_pkg::ST_ENV_B: begin
        acc_d   = mac_res;
        state_d = sngx_pkg::ST_DROP;
      end
      sngx_pkg::ST_DROP: begin
        env_d[ch_q] = env_new;
        below_d     = env_new < {1'b0, thresh_q};
        acc_d       = mac_res;
        state_d     = sngx_pkg::ST_GAIN;
      end
      sngx_pkg::ST_GAIN: begin
        if (!below_q) begin
          gain_d = sngx_pkg::Unity;
        end else if (drop >= 27'(sngx_pkg::Unity)) begin
          gain_d = '0;
        end else begin
          gain_d = sngx_pkg::Unity - drop[16:0];
        end
        state_d = sngx_pkg::ST_MULT;
      end
      sngx_pkg::ST_MULT: begin
        acc_d   = mac_res;
        state_d = sngx_pkg::ST_STORE;
      end
      sngx_pkg::ST_STORE: begin
        if (!ch_q) begin
          yl_d    = y_val;
          ch_d    = 1'b1;
          state_d = sngx_pkg::ST_SCALE;
        end else begin
          yl_d    = yl_q;
          state_d = sngx_pkg::ST_SEND;
          if (out_free) begin
            m_valid_d = 1'b1;
            m_data_d  = bypass_q ? {x_q[1], x_q[0]} : {y_val, yl_q};
            m_last_d  = last_q;
            state_d   = sngx_pkg::ST_IDLE;
          end
        end
      end
      sngx_pkg::ST_SEND: begin
        // right result still in acc, wait for the output register
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = bypass_q ? {x_q[1], x_q[0]} : {y_val, yl_q};
          m_last_d  = last_q;
          state_d   = sngx_pkg::ST_IDLE;
        end
      end
      default: state_d = sngx_pkg::ST_IDLE;
    endcase

    // clearing the enable zeroes both envelopes
    if (cfg_valid && sngx_pkg::cfg_reg_e'(cfg_index) == sngx_pkg::REG_GATE_ENABLE
        && !cfg_data[0]) begin
      env_d[0] = '0;
      env_d[1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_gain_q <= sngx_pkg::RstInputGain;
      gate_en_q <= sngx_pkg::RstGateEn;
      thresh_q  <= sngx_pkg::RstThreshold;
      attack_q  <= sngx_pkg::RstAttack;
      release_q <= sngx_pkg::RstRelease;
      slope_q   <= sngx_pkg::RstSlope;
      bypass_q  <= sngx_pkg::RstBypass;
    end else if (cfg_valid) begin
      unique case (sngx_pkg::cfg_reg_e'(cfg_index))
        sngx_pkg::REG_INPUT_GAIN:      in_gain_q <= cfg_data[16:0];
        sngx_pkg::REG_GATE_ENABLE:     gate_en_q <= cfg_data[0];
        sngx_pkg::REG_GATE_THRESHOLD:  thresh_q  <= cfg_data[22:0];
        sngx_pkg::REG_ATTACK_COEFF:    attack_q  <= cfg_data[15:0];
        sngx_pkg::REG_RELEASE_COEFF:   release_q <= cfg_data[15:0];
        sngx_pkg::REG_EXPANSION_SLOPE: slope_q   <= cfg_data;
        sngx_pkg::REG_BYPASS:          bypass_q  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sngx_pkg::ST_IDLE;
      ch_q      <= 1'b0;
      env_q[0]  <= '0;
      env_q[1]  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      env_q     <= env_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    last_q   <= last_d;
    lvl_q    <= lvl_d;
    neg_q    <= neg_d;
    below_q  <= below_d;
    gain_q   <= gain_d;
    acc_q    <= acc_d;
    yl_q     <= yl_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  a_env_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_index == sngx_pkg::REG_GATE_ENABLE && !cfg_data[0]
    |=> env_q[0] == '0 && env_q[1] == '0)
    else $error("envelopes not cleared by gate disable");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q[0] <= sngx_pkg::NegMagMax && env_q[1] <= sngx_pkg::NegMagMax)
    else $error("envelope above full scale");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == sngx_pkg::ST_SCALE && !ch_q)
    else $error("input transfer did not start the left channel");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sngx_pkg::ST_MULT |-> gain_q <= sngx_pkg::Unity)
    else $error("channel gain above unity");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> state_q != sngx_pkg::ST_IDLE || m_axis_tvalid)
    else $error("pending result dropped");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sngx_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused   = 3'd7;
  localparam int unsigned        SettleCycles = 24;
  localparam int unsigned        NumPhases    = 22;
  localparam int unsigned        PhaseItems   = 50;

  typedef struct {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic               last;
  } pair_t;

  // gate model, its register copy and the pairs still owed by the block
  class gate_scoreboard;
    logic [GainW-1:0]   gain;
    logic               enable;
    logic [ThreshW-1:0] thresh;
    logic [CoeffW-1:0]  attack;
    logic [CoeffW-1:0]  release_c;
    logic [SlopeW-1:0]  slope;
    logic               bypass;
    logic [SampleW-1:0] env_l;
    logic [SampleW-1:0] env_r;
    pair_t              expected_pairs[$];
    int unsigned        errors;

    function new();
      gain      = RstInputGain;
      enable    = RstGateEn;
      thresh    = RstThreshold;
      attack    = RstAttack;
      release_c = RstRelease;
      slope     = RstSlope;
      bypass    = RstBypass;
      env_l     = '0;
      env_r     = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_INPUT_GAIN:      gain = data[GainW-1:0];
        REG_GATE_ENABLE: begin
          enable = data[0];
          if (!data[0]) begin
            env_l = '0;
            env_r = '0;
          end
        end
        REG_GATE_THRESHOLD:  thresh = data[ThreshW-1:0];
        REG_ATTACK_COEFF:    attack = data[CoeffW-1:0];
        REG_RELEASE_COEFF:   release_c = data[CoeffW-1:0];
        REG_EXPANSION_SLOPE: slope = data[SlopeW-1:0];
        REG_BYPASS:          bypass = data[0];
        default: ;
      endcase
    endfunction

    // x * g / 2^16, halves rounded away from zero
    function longint scale_q16(longint x, longint g);
      longint mag;
      mag = (x < 0) ? -x : x;
      mag = (mag * g + longint'(RndQ16)) >> 16;
      return (x < 0) ? -mag : mag;
    endfunction

    function longint clamp_s24(longint v);
      if (v > longint'(8388607)) return 8388607;
      if (v < -longint'(8388608)) return -8388608;
      return v;
    endfunction

    function longint gate_sample(longint s, inout logic [SampleW-1:0] env);
      longint level, e, c, g, diff, drop;
      level = (s < 0) ? -s : s;
      e     = longint'(env);
      c     = (level > e) ? longint'(attack) : longint'(release_c);
      e     = (c * e + (longint'(Unity) - c) * level + longint'(RndQ16)) >> 16;
      env   = e[SampleW-1:0];
      g     = longint'(Unity);
      if (e < longint'(thresh)) begin
        diff = longint'(thresh) - e;
        drop = (diff * longint'(slope) + longint'(RndQ23)) >> 23;
        g    = (drop >= longint'(Unity)) ? 0 : longint'(Unity) - drop;
      end
      return scale_q16(s, g);
    endfunction

    function void predict_pair(logic [47:0] data, logic last);
      pair_t  p;
      longint xl, xr, yl, yr;
      xl = longint'($signed(data[23:0]));
      xr = longint'($signed(data[47:24]));
      yl = clamp_s24(scale_q16(xl, longint'(gain)));
      yr = clamp_s24(scale_q16(xr, longint'(gain)));
      if (enable) begin
        yl = gate_sample(yl, env_l);
        yr = gate_sample(yr, env_r);
      end
      if (bypass) begin
        yl = xl;
        yr = xr;
      end
      p.left  = yl[SampleW-1:0];
      p.right = yr[SampleW-1:0];
      p.last  = last;
      expected_pairs.push_back(p);
    endfunction

    function void check_pair(logic [47:0] data, logic last);
      pair_t p;
      if (expected_pairs.size() == 0) begin
        $display("%0t: result with nothing expected: data %h last %b", $time, data, last);
        errors++;
        return;
      end
      p = expected_pairs.pop_front();
      if (data[23:0] !== p.left) begin
        $display("%0t: left mismatch: expected %h actual %h", $time, p.left, data[23:0]);
        errors++;
      end
      if (data[47:24] !== p.right) begin
        $display("%0t: right mismatch: expected %h actual %h", $time, p.right, data[47:24]);
        errors++;
      end
      if (last !== p.last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, p.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [47:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  gate_scoreboard sb;
  logic           tx_steady;
  logic           rx_steady;

  stereo_noise_gate_expander_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // transfers seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.predict_pair(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_pair(m_axis_tdata, m_axis_tlast);
    end
  end

  // output back-pressure: mostly short stalls, now and then a long one
  initial begin
    int unsigned stall_left;
    int unsigned pick;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 7) == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 16)      stall_left = $urandom_range(1, 3);
          else if (pick < 19) stall_left = $urandom_range(4, 12);
          else                stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  task automatic send_pair(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r,
                           input logic last);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (!tx_steady) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      gap = 0;
      else if (pick < 17) gap = $urandom_range(1, 3);
      else if (pick < 19) gap = $urandom_range(4, 15);
      else                gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the input until every pair owed has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic shuffle_config();
    logic [CfgW-1:0] v;
    int unsigned     pick;
    for (int i = 0; i <= 6; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        pick = $urandom_range(0, 5);
        v    = CfgW'($urandom());
        case (cfg_reg_e'(i))
          REG_INPUT_GAIN: begin
            case (pick)
              0: v = '0;
              1: v = CfgW'(Unity);
              2: v = CfgW'(17'h1ffff);
              3: v = CfgW'($urandom_range(0, 65536));
              4: ;
              default: v = CfgW'($urandom_range(8000, 30000));
            endcase
          end
          REG_GATE_ENABLE: begin
            if (pick == 0)      v = '0;
            else if (pick != 5) v = CfgW'(1);
          end
          REG_GATE_THRESHOLD: begin
            case (pick)
              0: v = '0;
              1: v = CfgW'(8389);
              2: v = CfgW'(23'h7fffff);
              3: v = CfgW'($urandom_range(0, 23'h7fffff));
              4: v = CfgW'($urandom_range(8389, 400000));
              default: ;
            endcase
          end
          REG_ATTACK_COEFF, REG_RELEASE_COEFF: begin
            case (pick)
              0: v = '0;
              1: v = CfgW'(16'hffff);
              2: v = CfgW'($urandom_range(0, 65535));
              3, 4: v = CfgW'($urandom_range(60000, 65535));
              default: ;
            endcase
          end
          REG_EXPANSION_SLOPE: begin
            case (pick)
              0: v = '0;
              1: v = CfgW'(26'h3ffffff);
              2, 3: v = CfgW'($urandom_range(100000, 8000000));
              default: ;
            endcase
          end
          default: begin
            v = (pick == 0) ? CfgW'(1) : '0;
          end
        endcase
        write_cfg(CfgIdxW'(i), v);
      end
    end
    if ($urandom_range(0, 7) == 0) write_cfg(RegUnused, CfgW'($urandom()));
  endtask

  initial begin
    int unsigned          seg_l;
    longint               amp_l, amp_r, vl, vr;
    int unsigned          kind;
    logic [SampleW-1:0]   sl, sr;
    logic                 last;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    sb            = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, gate off: scaled samples pass through
    send_pair(24'h7fffff, 24'h800000, 1'b0);
    send_pair(24'h800000, 24'h7fffff, 1'b1);
    send_pair(24'h000000, 24'h000000, 1'b0);
    send_pair(24'hffffff, 24'h000001, 1'b1);
    wait_drained();

    // gain above unity saturates, with the gate enabled
    write_cfg(REG_INPUT_GAIN, CfgW'(17'h1ffff));
    write_cfg(REG_GATE_ENABLE, CfgW'(1));
    send_pair(24'h7fffff, 24'h800000, 1'b0);
    send_pair(24'h400000, 24'hc00000, 1'b1);
    wait_drained();

    // highest threshold and slope, instant attack, slowest release
    write_cfg(REG_INPUT_GAIN, CfgW'(Unity));
    write_cfg(REG_GATE_THRESHOLD, CfgW'(23'h7fffff));
    write_cfg(REG_EXPANSION_SLOPE, CfgW'(26'h3ffffff));
    write_cfg(REG_ATTACK_COEFF, '0);
    write_cfg(REG_RELEASE_COEFF, CfgW'(16'hffff));
    send_pair(24'h000100, 24'hffff00, 1'b0);
    send_pair(24'h7fffff, 24'h800000, 1'b0);
    send_pair(24'h000000, 24'h000000, 1'b1);
    wait_drained();

    // zero threshold keeps unity gain
    write_cfg(REG_GATE_THRESHOLD, '0);
    send_pair(24'h000005, 24'hfffffb, 1'b0);
    send_pair(24'h3fffff, 24'hc00001, 1'b1);
    wait_drained();

    // bypass while the envelopes keep moving
    write_cfg(REG_GATE_THRESHOLD, CfgW'(83886));
    write_cfg(REG_EXPANSION_SLOPE, CfgW'(5898240));
    write_cfg(REG_ATTACK_COEFF, CfgW'(16'hffff));
    write_cfg(REG_RELEASE_COEFF, '0);
    write_cfg(REG_BYPASS, CfgW'(1));
    send_pair(24'h123456, 24'hedcba9, 1'b0);
    send_pair(24'h7fffff, 24'h800000, 1'b0);
    send_pair(24'h000010, 24'hfffff0, 1'b1);
    wait_drained();

    // disabling clears the envelopes; unused index is ignored
    write_cfg(REG_GATE_ENABLE, '0);
    write_cfg(REG_BYPASS, '0);
    write_cfg(RegUnused, CfgW'($urandom()));
    send_pair(24'h0a0a0a, 24'hf5f5f5, 1'b0);
    send_pair(24'h555555, 24'haaaaaa, 1'b1);
    wait_drained();

    // writes wider than the register are masked
    write_cfg(REG_GATE_ENABLE, CfgW'(26'h3ffffff));
    write_cfg(REG_INPUT_GAIN, CfgW'(26'h3ffffff));
    write_cfg(REG_ATTACK_COEFF, CfgW'(26'h3ffffff));
    send_pair(24'h000800, 24'hfff800, 1'b0);
    send_pair(24'h200000, 24'he00000, 1'b0);
    send_pair(24'h000001, 24'hffffff, 1'b1);
    wait_drained();

    // random phases: bursts of a given loudness so the envelopes rise and decay
    seg_l = 0;
    amp_l = 0;
    amp_r = 0;
    kind  = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      shuffle_config();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        if (seg_l == 0) begin
          seg_l = $urandom_range(4, 40);
          kind  = $urandom_range(0, 9);
          case (kind)
            0:       amp_l = 0;
            1, 2:    amp_l = $urandom_range(0, 255);
            3, 4, 5: amp_l = $urandom_range(0, 2 * sb.thresh + 16);
            default: amp_l = $urandom_range(0, 24'h7fffff);
          endcase
          amp_r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'h7fffff) : amp_l;
          if (amp_l > longint'(24'h7fffff)) amp_l = 24'h7fffff;
          if (amp_r > longint'(24'h7fffff)) amp_r = 24'h7fffff;
        end
        seg_l--;
        if ($urandom_range(0, 15) == 0) begin
          sl = SampleW'($urandom());
          sr = SampleW'($urandom());
        end else begin
          vl = longint'($urandom_range(0, 32'(2 * amp_l))) - amp_l;
          vr = longint'($urandom_range(0, 32'(2 * amp_r))) - amp_r;
          sl = vl[SampleW-1:0];
          sr = vr[SampleW-1:0];
        end
        last = (seg_l == 0) || ($urandom_range(0, 7) == 0);
        send_pair(sl, sr, last);
      end
      wait_drained();
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
